[hw/rtl/bhpq_pkg.sv]
// ----------------------------------------------------------------------------
// bhpq_pkg
// Types, codes and sizes shared by the binary max-heap priority queue core.
// ----------------------------------------------------------------------------
package bhpq_pkg;

	localparam int DEF_CAPACITY  = 64;
	localparam int DEF_KEY_WIDTH = 32;

	localparam int OP_W    = 2;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 7;
	localparam int STS_W   = 3;
	localparam int COUNT_W = 7;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 2'd0,
		OP_EXTRACT  = 2'd1,
		OP_INCREASE = 2'd2
	} op_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK         = 3'd0,
		STS_EMPTY      = 3'd1,
		STS_FULL       = 3'd2,
		STS_BAD_POS    = 3'd3,
		STS_NOT_LARGER = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_EX_LOAD,
		S_INC_CHECK,
		S_UP_READ,
		S_UP_CMP,
		S_DN_READ,
		S_DN_CMP,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]           operation;
		logic signed [VALUE_W-1:0] key_value;
		logic [POS_W-1:0]          entry_position;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] result_value;
		status_t                   status;
		logic [COUNT_W-1:0]        entry_count;
	} rsp_t;

	typedef struct packed {
		logic    load_in;
		logic    start_ins;
		logic    rd_pos;
		logic    rd_ends;
		logic    ld_ext;
		logic    rd_parent;
		logic    up_move;
		logic    rd_kids;
		logic    dn_move;
		logic    wr_key;
		logic    set_st;
		status_t st_code;
		logic    ld_out;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            full;
		logic            empty;
		logic            pos_ok;
		logic            not_larger;
		logic            at_root;
		logic            up_larger;
		logic            has_l;
		logic            child_wins;
	} sts_t;

endpackage

[hw/rtl/bhpq_datapath.sv]
// ----------------------------------------------------------------------------
// bhpq_datapath
// Heap memory, moving key, hole position, entry count and response register.
// ----------------------------------------------------------------------------
module bhpq_datapath #(
	parameter int CAPACITY  = bhpq_pkg::DEF_CAPACITY,
	parameter int KEY_WIDTH = bhpq_pkg::DEF_KEY_WIDTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bhpq_pkg::req_t  req,
	input  bhpq_pkg::cmd_t  cmd,
	output bhpq_pkg::sts_t  sts,
	output bhpq_pkg::rsp_t  rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PW = $clog2(CAPACITY + 1);

	logic [KEY_WIDTH-1:0] mem [CAPACITY];

	logic [bhpq_pkg::OP_W-1:0]    op_q;
	logic [bhpq_pkg::POS_W-1:0]   pos_q;
	logic [KEY_WIDTH-1:0]         key_q;
	logic [PW-1:0]                hole_q;
	logic [PW-1:0]                count_q;
	logic [KEY_WIDTH-1:0]         rd_a_q;
	logic [KEY_WIDTH-1:0]         rd_b_q;
	logic [bhpq_pkg::VALUE_W-1:0] res_q;
	bhpq_pkg::status_t            status_q;
	bhpq_pkg::rsp_t               rsp_q;

	logic [63:0]          key_ext;
	logic [63:0]          res_ext;
	logic [AW-1:0]        addr_a;
	logic [AW-1:0]        addr_b;
	logic [AW-1:0]        addr_w;
	logic                 wr_en;
	logic [KEY_WIDTH-1:0] wr_data;
	logic                 has_r;
	logic                 l_win;
	logic                 r_win;
	logic [KEY_WIDTH-1:0] best_l;
	logic [KEY_WIDTH-1:0] best_val;
	logic [PW-1:0]        best_pos;

	assign key_ext = 64'($signed(req.key_value));
	assign res_ext = 64'($signed(rd_a_q));

	always_comb begin
		addr_a = '0;
		addr_b = '0;
		if (cmd.rd_pos) begin
			addr_a = AW'(int'(pos_q) - 1);
		end else if (cmd.rd_parent) begin
			addr_a = AW'(int'(hole_q >> 1) - 1);
		end else if (cmd.rd_kids) begin
			addr_a = AW'(2 * int'(hole_q) - 1);
			addr_b = AW'(2 * int'(hole_q));
		end else if (cmd.rd_ends) begin
			addr_b = AW'(int'(count_q) - 1);
		end
	end

	assign sts.has_l = (2 * int'(hole_q)) <= int'(count_q);
	assign has_r     = (2 * int'(hole_q) + 1) <= int'(count_q);
	assign l_win     = sts.has_l && ($signed(rd_a_q) > $signed(key_q));
	assign best_l    = l_win ? rd_a_q : key_q;
	assign r_win     = has_r && ($signed(rd_b_q) > $signed(best_l));
	assign best_val  = r_win ? rd_b_q : best_l;
	assign best_pos  = r_win ? PW'(2 * int'(hole_q) + 1) : PW'(2 * int'(hole_q));

	assign sts.op         = op_q;
	assign sts.full       = int'(count_q) >= CAPACITY;
	assign sts.empty      = count_q == '0;
	assign sts.pos_ok     = (pos_q != '0) && (int'(pos_q) <= int'(count_q));
	assign sts.not_larger = $signed(rd_a_q) >= $signed(key_q);
	assign sts.at_root    = hole_q == PW'(1);
	assign sts.up_larger  = $signed(key_q) > $signed(rd_a_q);
	assign sts.child_wins = l_win || r_win;

	assign addr_w = AW'(int'(hole_q) - 1);
	assign wr_en  = cmd.wr_key || cmd.up_move || cmd.dn_move;

	always_comb begin
		wr_data = key_q;
		if (cmd.up_move) begin
			wr_data = rd_a_q;
		end else if (cmd.dn_move) begin
			wr_data = best_val;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_w] <= wr_data;
		end
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.start_ins) begin
			count_q <= count_q + PW'(1);
		end else if (cmd.ld_ext) begin
			count_q <= count_q - PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= req.operation;
			pos_q    <= req.entry_position;
			key_q    <= key_ext[KEY_WIDTH-1:0];
			res_q    <= '0;
			status_q <= bhpq_pkg::STS_OK;
		end
		if (cmd.set_st) begin
			status_q <= cmd.st_code;
		end
		if (cmd.start_ins) begin
			hole_q <= count_q + PW'(1);
		end
		if (cmd.rd_pos) begin
			hole_q <= PW'(pos_q);
		end
		if (cmd.ld_ext) begin
			res_q  <= res_ext[bhpq_pkg::VALUE_W-1:0];
			key_q  <= rd_b_q;
			hole_q <= PW'(1);
		end
		if (cmd.up_move) begin
			hole_q <= hole_q >> 1;
		end
		if (cmd.dn_move) begin
			hole_q <= best_pos;
		end
		if (cmd.ld_out) begin
			rsp_q.result_value <= res_q;
			rsp_q.status       <= status_q;
			rsp_q.entry_count  <= bhpq_pkg::COUNT_W'(count_q);
		end
	end

	assign rsp = rsp_q;

endmodule

[hw/rtl/bhpq_ctrl.sv]
// ----------------------------------------------------------------------------
// bhpq_ctrl
// Sequencer for insert, extract and increase-key, and response valid.
// ----------------------------------------------------------------------------
module bhpq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	input  bhpq_pkg::sts_t sts,
	output bhpq_pkg::cmd_t cmd
);

	bhpq_pkg::state_t state_q;
	bhpq_pkg::state_t state_nxt;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = state_q != bhpq_pkg::S_IDLE;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bhpq_pkg::S_IDLE: begin
				if (req_valid) state_nxt = bhpq_pkg::S_DECODE;
			end
			bhpq_pkg::S_DECODE: begin
				case (sts.op)
					bhpq_pkg::OP_INSERT:
						state_nxt = sts.full ? bhpq_pkg::S_RESP : bhpq_pkg::S_UP_READ;
					bhpq_pkg::OP_EXTRACT:
						state_nxt = sts.empty ? bhpq_pkg::S_RESP : bhpq_pkg::S_EX_LOAD;
					bhpq_pkg::OP_INCREASE:
						state_nxt = sts.pos_ok ? bhpq_pkg::S_INC_CHECK : bhpq_pkg::S_RESP;
					default:
						state_nxt = bhpq_pkg::S_RESP;
				endcase
			end
			bhpq_pkg::S_EX_LOAD:   state_nxt = bhpq_pkg::S_DN_READ;
			bhpq_pkg::S_INC_CHECK:
				state_nxt = sts.not_larger ? bhpq_pkg::S_RESP : bhpq_pkg::S_UP_READ;
			bhpq_pkg::S_UP_READ:
				state_nxt = sts.at_root ? bhpq_pkg::S_RESP : bhpq_pkg::S_UP_CMP;
			bhpq_pkg::S_UP_CMP:
				state_nxt = sts.up_larger ? bhpq_pkg::S_UP_READ : bhpq_pkg::S_RESP;
			bhpq_pkg::S_DN_READ:
				state_nxt = sts.has_l ? bhpq_pkg::S_DN_CMP : bhpq_pkg::S_RESP;
			bhpq_pkg::S_DN_CMP:
				state_nxt = sts.child_wins ? bhpq_pkg::S_DN_READ : bhpq_pkg::S_RESP;
			bhpq_pkg::S_RESP: begin
				if (out_free) state_nxt = bhpq_pkg::S_IDLE;
			end
			default: state_nxt = bhpq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.st_code = bhpq_pkg::STS_OK;
		case (state_q)
			bhpq_pkg::S_IDLE: cmd.load_in = req_valid;
			bhpq_pkg::S_DECODE: begin
				case (sts.op)
					bhpq_pkg::OP_INSERT: begin
						if (sts.full) begin
							cmd.set_st  = 1'b1;
							cmd.st_code = bhpq_pkg::STS_FULL;
						end else begin
							cmd.start_ins = 1'b1;
						end
					end
					bhpq_pkg::OP_EXTRACT: begin
						if (sts.empty) begin
							cmd.set_st  = 1'b1;
							cmd.st_code = bhpq_pkg::STS_EMPTY;
						end else begin
							cmd.rd_ends = 1'b1;
						end
					end
					bhpq_pkg::OP_INCREASE: begin
						if (sts.pos_ok) begin
							cmd.rd_pos = 1'b1;
						end else begin
							cmd.set_st  = 1'b1;
							cmd.st_code = bhpq_pkg::STS_BAD_POS;
						end
					end
					default: cmd.set_st = 1'b0;
				endcase
			end
			bhpq_pkg::S_EX_LOAD: cmd.ld_ext = 1'b1;
			bhpq_pkg::S_INC_CHECK: begin
				if (sts.not_larger) begin
					cmd.set_st  = 1'b1;
					cmd.st_code = bhpq_pkg::STS_NOT_LARGER;
				end
			end
			bhpq_pkg::S_UP_READ: begin
				cmd.wr_key    = sts.at_root;
				cmd.rd_parent = !sts.at_root;
			end
			bhpq_pkg::S_UP_CMP: begin
				cmd.up_move = sts.up_larger;
				cmd.wr_key  = !sts.up_larger;
			end
			bhpq_pkg::S_DN_READ: begin
				cmd.rd_kids = sts.has_l;
				cmd.wr_key  = !sts.has_l;
			end
			bhpq_pkg::S_DN_CMP: begin
				cmd.dn_move = sts.child_wins;
				cmd.wr_key  = !sts.child_wins;
			end
			bhpq_pkg::S_RESP: cmd.ld_out = out_free;
			default: cmd.load_in = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bhpq_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/binary_max_heap_priority_queue_core.sv]
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_core
// Binary max-heap of signed keys: insert, extract maximum, increase key.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req, req_valid, req_stall) carries one operation word;
//   rsp channel (rsp, rsp_valid, rsp_stall) returns exactly one word per
//   request, in order: removed maximum (extract), status and entry count.
//   One request is worked at a time; req_stall is high from the cycle after
//   acceptance until the response is loaded into the output register.
//   Each heap level takes a memory read step (UP_READ or DN_READ) and a
//   compare/write step (UP_CMP or DN_CMP) on the single heap RAM; the
//   moving key stays in a register.
//   Reset empties the heap at once (entry count cleared, no memory sweep).
//   A stalled response holds in the output register; the next request is
//   taken meanwhile and waits in its last step until the register frees.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_core #(
	parameter int CAPACITY  = bhpq_pkg::DEF_CAPACITY,
	parameter int KEY_WIDTH = bhpq_pkg::DEF_KEY_WIDTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bhpq_pkg::req_t req,
	input  logic           req_valid,
	output logic           req_stall,
	output bhpq_pkg::rsp_t rsp,
	output logic           rsp_valid,
	input  logic           rsp_stall
);

	bhpq_pkg::cmd_t cmd;
	bhpq_pkg::sts_t sts;

	bhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bhpq_datapath #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |-> !(rsp_valid && rsp_stall))
		else $error("response register loaded while a stalled word is held");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request channel open right after acceptance");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_key, cmd.up_move, cmd.dn_move}))
		else $error("more than one heap write source selected");

endmodule

[tb/sv/heap_response_checker.sv]
// ----------------------------------------------------------------------------
// heap_response_checker
// Watches both channels of the heap core. Keeps its own max-heap of the keys,
// predicts the response word of every accepted request and compares each
// accepted response word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module heap_response_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  bhpq_pkg::req_t req,
	input  logic           req_valid,
	input  logic           req_stall,
	input  bhpq_pkg::rsp_t rsp,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	output int             fail_count,
	output int             pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = bhpq_pkg::DEF_CAPACITY;

	logic signed [bhpq_pkg::VALUE_W-1:0] keys [1:CAP];
	int                                  held;
	bhpq_pkg::rsp_t                      due_q [$];
	bhpq_pkg::rsp_t                      due;
	bit                                  word_bad;

	function automatic bhpq_pkg::rsp_t heap_apply(bhpq_pkg::req_t w);
		bhpq_pkg::rsp_t                      r;
		int                                  p;
		int                                  best;
		int                                  kid;
		bit                                  climb;
		bit                                  moving;
		logic signed [bhpq_pkg::VALUE_W-1:0] k;
		logic signed [bhpq_pkg::VALUE_W-1:0] tmp;
		r.result_value = '0;
		r.status = bhpq_pkg::STS_OK;
		climb = 1'b0;
		p = 0;
		k = $signed(w.key_value);
		case (w.operation)
			bhpq_pkg::OP_INSERT: begin
				if (held >= CAP) begin
					r.status = bhpq_pkg::STS_FULL;
				end else begin
					held++;
					keys[held] = k;
					p = held;
					climb = 1'b1;
				end
			end
			bhpq_pkg::OP_EXTRACT: begin
				if (held == 0) begin
					r.status = bhpq_pkg::STS_EMPTY;
				end else begin
					r.result_value = keys[1];
					keys[1] = keys[held];
					held--;
					p = 1;
					moving = 1'b1;
					while (moving) begin
						best = p;
						kid = 2 * p;
						if (kid <= held && keys[kid] > keys[best]) best = kid;
						if (kid + 1 <= held && keys[kid + 1] > keys[best]) best = kid + 1;
						if (best == p) begin
							moving = 1'b0;
						end else begin
							tmp = keys[p];
							keys[p] = keys[best];
							keys[best] = tmp;
							p = best;
						end
					end
				end
			end
			bhpq_pkg::OP_INCREASE: begin
				p = int'(w.entry_position);
				if (p < 1 || p > held) begin
					r.status = bhpq_pkg::STS_BAD_POS;
				end else if (keys[p] >= k) begin
					r.status = bhpq_pkg::STS_NOT_LARGER;
				end else begin
					keys[p] = k;
					climb = 1'b1;
				end
			end
			default: ;
		endcase
		if (climb) begin
			while (p > 1 && keys[p] > keys[p / 2]) begin
				tmp = keys[p];
				keys[p] = keys[p / 2];
				keys[p / 2] = tmp;
				p = p / 2;
			end
		end
		r.entry_count = held[bhpq_pkg::COUNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			due_q.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (due_q.size() == 0) begin
					$display("%0t: response word with nothing expected: value %0d status %0d count %0d",
						$time, rsp.result_value, rsp.status, rsp.entry_count);
					fail_count++;
				end else begin
					due = due_q.pop_front();
					word_bad = 1'b0;
					if (rsp.result_value !== due.result_value) begin
						$display("%0t: result_value expected %0d actual %0d",
							$time, due.result_value, rsp.result_value);
						word_bad = 1'b1;
					end
					if (rsp.status !== due.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, due.status, rsp.status);
						word_bad = 1'b1;
					end
					if (rsp.entry_count !== due.entry_count) begin
						$display("%0t: entry_count expected %0d actual %0d",
							$time, due.entry_count, rsp.entry_count);
						word_bad = 1'b1;
					end
					if (word_bad) fail_count++;
				end
			end
			if (req_valid && !req_stall) due_q.push_back(heap_apply(req));
			pending_count = due_q.size();
		end
	end

endmodule

[tb/sv/binary_max_heap_priority_queue_core_tb.sv]
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_core_tb
// Drives the heap core with a directed run of the edge cases and then long
// random runs that fill, drain and mix the heap, with random idling on both
// channels and one long response hold-off. The checker predicts and compares.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP       = bhpq_pkg::DEF_CAPACITY;
	localparam int ITEMS     = 1600;
	localparam int RUN_LIMIT = 400000;
	localparam int HOLD_AT   = 3000;
	localparam int HOLD_LEN  = 400;
	localparam int TAIL      = 40;

	localparam logic [bhpq_pkg::OP_W-1:0]           OP_UNUSED = 2'd3;
	localparam logic signed [bhpq_pkg::VALUE_W-1:0] KEY_MAX   = 32'sh7fff_ffff;
	localparam logic signed [bhpq_pkg::VALUE_W-1:0] KEY_MIN   = 32'sh8000_0000;

	logic           clk;
	logic           arst_n;
	bhpq_pkg::req_t req;
	logic           req_valid;
	logic           req_stall;
	bhpq_pkg::rsp_t rsp;
	logic           rsp_valid;
	logic           rsp_stall;

	int fail_count;
	int pending_count;
	int cycles;
	int rx_cycles;
	int fill;
	bit quiet;

	binary_max_heap_priority_queue_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

	heap_response_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.rsp           (rsp),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("binary_max_heap_priority_queue_core_tb: done, errors");
		$finish;
	end

	// hold off for a long stretch once, otherwise stall at random unless quiet
	initial begin
		rsp_stall = 1'b0;
		rx_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_cycles++;
			if (rx_cycles >= HOLD_AT && rx_cycles < HOLD_AT + HOLD_LEN) rsp_stall <= 1'b1;
			else if (quiet) rsp_stall <= 1'b0;
			else rsp_stall <= ($urandom_range(0, 99) < 33);
		end
	end

	task automatic send_word(bhpq_pkg::req_t w);
		if (!quiet) begin
			while ($urandom_range(0, 99) < 33) begin
				req_valid <= 1'b0;
				@(negedge clk);
			end
		end
		req <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_op(logic [bhpq_pkg::OP_W-1:0] op,
			logic signed [bhpq_pkg::VALUE_W-1:0] key, logic [bhpq_pkg::POS_W-1:0] pos);
		bhpq_pkg::req_t w;
		w.operation = op;
		w.key_value = key;
		w.entry_position = pos;
		if (op == bhpq_pkg::OP_INSERT && fill < CAP) fill++;
		else if (op == bhpq_pkg::OP_EXTRACT && fill > 0) fill--;
		send_word(w);
	endtask

	function automatic logic signed [bhpq_pkg::VALUE_W-1:0] pick_key();
		logic signed [bhpq_pkg::VALUE_W-1:0] k;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: k = KEY_MAX;
					1: k = KEY_MIN;
					2: k = '0;
					default: k = -1;
				endcase
			end
			1, 2, 3: k = $signed($urandom_range(0, 16)) - 8;
			default: k = $urandom;
		endcase
		return k;
	endfunction

	function automatic logic [bhpq_pkg::POS_W-1:0] pick_pos(int held);
		if (held > 0 && $urandom_range(0, 99) < 80)
			return bhpq_pkg::POS_W'($urandom_range(1, held));
		return bhpq_pkg::POS_W'($urandom_range(0, 127));
	endfunction

	initial begin
		int                                  sent;
		int                                  left;
		int                                  mode;
		int                                  roll;
		int                                  ins_pct;
		int                                  ext_pct;
		logic [bhpq_pkg::OP_W-1:0]           op;
		logic signed [bhpq_pkg::VALUE_W-1:0] key;
		arst_n = 1'b0;
		req = '0;
		req_valid = 1'b0;
		quiet = 1'b0;
		fill = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_op(bhpq_pkg::OP_EXTRACT, 0, 1);
		send_op(bhpq_pkg::OP_INCREASE, 0, 1);
		send_op(OP_UNUSED, -1, 127);
		send_op(bhpq_pkg::OP_INSERT, 5, 0);
		send_op(bhpq_pkg::OP_INCREASE, 5, 1);
		send_op(bhpq_pkg::OP_INCREASE, 4, 1);
		send_op(bhpq_pkg::OP_INCREASE, KEY_MAX, 1);
		send_op(bhpq_pkg::OP_INSERT, KEY_MIN, 64);
		send_op(bhpq_pkg::OP_INSERT, 0, 0);
		send_op(bhpq_pkg::OP_INSERT, -1, 127);
		send_op(bhpq_pkg::OP_INCREASE, 0, 0);
		send_op(bhpq_pkg::OP_INCREASE, KEY_MAX, 127);
		send_op(bhpq_pkg::OP_INCREASE, 1, 5);
		send_op(bhpq_pkg::OP_INCREASE, 100, 4);
		send_op(bhpq_pkg::OP_INSERT, KEY_MAX, 1);
		send_op(bhpq_pkg::OP_INCREASE, KEY_MAX, 2);
		repeat (6) send_op(bhpq_pkg::OP_EXTRACT, -1, 0);
		send_op(bhpq_pkg::OP_INSERT, KEY_MIN, 0);
		send_op(bhpq_pkg::OP_INCREASE, KEY_MIN + 1, 1);
		send_op(bhpq_pkg::OP_EXTRACT, 0, 0);

		sent = 0;
		left = 0;
		mode = 0;
		while (sent < ITEMS) begin
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(40, 200);
			end
			left--;
			quiet = (sent >= 700 && sent < 1000);
			case (mode)
				0: begin ins_pct = 65; ext_pct = 15; end
				1: begin ins_pct = 15; ext_pct = 65; end
				default: begin ins_pct = 35; ext_pct = 35; end
			endcase
			roll = $urandom_range(0, 99);
			if (roll < ins_pct) op = bhpq_pkg::OP_INSERT;
			else if (roll < ins_pct + ext_pct) op = bhpq_pkg::OP_EXTRACT;
			else if (roll < 98) op = bhpq_pkg::OP_INCREASE;
			else op = OP_UNUSED;
			key = pick_key();
			if (op == bhpq_pkg::OP_INCREASE && $urandom_range(0, 1))
				key[bhpq_pkg::VALUE_W-1] = 1'b0;
			send_op(op, key, pick_pos(fill));
			if (op != OP_UNUSED) sent++;
		end
		quiet = 1'b0;
		req_valid <= 1'b0;

		wait (pending_count == 0);
		repeat (TAIL) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("binary_max_heap_priority_queue_core_tb: done, clean");
		end else begin
			$display("binary_max_heap_priority_queue_core_tb: done, errors");
		end
		$finish;
	end

endmodule
